/* rtl/core/lsq_slope_sliding_window_assert.svh */
// Assertion macros shared by the least-squares slope block.
// Included by modules that check their own control logic; no dependencies.
`ifndef LSQ_SLOPE_SLIDING_WINDOW_ASSERT_SVH
`define LSQ_SLOPE_SLIDING_WINDOW_ASSERT_SVH

// Hold cons in the same cycle as ante.
`define LSQS_CHECK(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("lsqs: same-cycle check failed");

// Hold cons in the cycle after ante.
`define LSQS_CHECK_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("lsqs: next-cycle check failed");

`endif

/* rtl/core/lsqs_pkg.sv */
// Shared types and constants of the least-squares slope block.
// No dependencies; imported by the controller, datapath and top level.
`default_nettype none

package lsqs_pkg;

  localparam int COV_W   = 25;
  localparam int SUM_W   = 21;
  localparam int SLOPE_W = 33;
  localparam int FRAC_W  = 16;
  localparam int SCALE_W = 32;
  localparam int HW_W    = 4;
  localparam int DATA_W  = 32;
  localparam int ADDR_W  = 3;
  localparam int PROD_W  = COV_W + SCALE_W + 1;

  localparam logic [HW_W-1:0]    HALF_RESET  = 4'd2;
  localparam logic [SCALE_W-1:0] SCALE_RESET = 32'd429496730;

  localparam logic [SLOPE_W-1:0] SLOPE_MAX = {1'b0, {(SLOPE_W-1){1'b1}}};
  localparam logic [SLOPE_W-1:0] SLOPE_MIN = {1'b1, {(SLOPE_W-1){1'b0}}};

  // register select: bit 2 of the byte address
  localparam logic REG_HALF  = 1'b0;
  localparam logic REG_SCALE = 1'b1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_UPDATE,
    S_MULT,
    S_EMIT
  } state_e;

  typedef struct packed {
    logic accept;
    logic update;
    logic mult;
    logic load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic none;
    logic final_res;
  } ctrl_sts_t;

endpackage

`default_nettype wire

/* rtl/core/lsqs_ctrl.sv */
// Sequencer of the least-squares slope block: accept, update, scale, emit.
// Depends on lsqs_pkg and lsq_slope_sliding_window_assert.svh.
`default_nettype none
`include "lsq_slope_sliding_window_assert.svh"

module lsqs_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output lsqs_pkg::ctrl_cmd_t cmd_o,
  input  lsqs_pkg::ctrl_sts_t sts_i
);
  import lsqs_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_UPDATE;
      end
      S_UPDATE: state_d = S_MULT;
      S_MULT: begin
        state_d = sts_i.none ? S_IDLE : S_EMIT;
      end
      S_EMIT: begin
        if (out_free && sts_i.final_res) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      S_IDLE:   cmd_o.accept = in_valid_i;
      S_UPDATE: cmd_o.update = 1'b1;
      S_MULT:   cmd_o.mult   = 1'b1;
      S_EMIT:   cmd_o.load   = out_free;
      default:  cmd_o = '0;
    endcase
  end

  always_comb begin
    if (cmd_o.load) begin
      out_valid_d = 1'b1;
    end else begin
      out_valid_d = out_valid_q && out_stall_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

  `LSQS_CHECK(a_emit_has_work, clk_i, rst_ni, state_q == S_EMIT, !sts_i.none)
  `LSQS_CHECK_NEXT(a_final_to_idle, clk_i, rst_ni, cmd_o.load && sts_i.final_res,
                   state_q == S_IDLE)
  `LSQS_CHECK_NEXT(a_one_item_at_a_time, clk_i, rst_ni, cmd_o.accept, !cmd_o.accept)

endmodule

`default_nettype wire

/* rtl/core/lsqs_datapath.sv */
// Datapath of the least-squares slope block: sample history memory, running
// covariance and window sum, scale multiplier and output register.
// Depends on lsqs_pkg and lsq_slope_sliding_window_assert.svh.
`default_nettype none
`include "lsq_slope_sliding_window_assert.svh"

module lsqs_datapath #(
  parameter int MAX_HALF    = 15,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  lsqs_pkg::ctrl_cmd_t                 cmd_i,
  output lsqs_pkg::ctrl_sts_t                 sts_o,
  input  logic signed [SAMPLE_BITS-1:0]       sample_i,
  input  logic                                column_end_i,
  input  logic [lsqs_pkg::HW_W-1:0]           half_width_i,
  input  logic [lsqs_pkg::SCALE_W-1:0]        slope_scale_i,
  output logic signed [lsqs_pkg::SLOPE_W-1:0] slope_o,
  output logic                                last_o,
  output logic                                short_column_o
);
  import lsqs_pkg::*;

  localparam int DEPTH  = 2 * MAX_HALF + 1;
  localparam int HALF_W = $clog2(MAX_HALF + 1);
  localparam int CNT_W  = HALF_W + 1;
  localparam int AW     = $clog2(DEPTH);
  localparam int RES_W  = $clog2(MAX_HALF + 2);
  localparam int QS_W   = PROD_W - FRAC_W;

  logic signed [SAMPLE_BITS-1:0] store_mem [DEPTH];

  // column state
  logic [AW-1:0]           wp_q;
  logic [CNT_W-1:0]        fill_q;
  logic [CNT_W-1:0]        hcnt_q;
  logic signed [COV_W-1:0] cov_q;
  logic signed [SUM_W-1:0] sum_q;
  logic [RES_W-1:0]        rem_q;
  logic                    first_q;

  // per-item payload
  logic signed [SAMPLE_BITS-1:0] x_q;
  logic signed [SAMPLE_BITS-1:0] xo_q;
  logic                          xo_ok_q;
  logic                          end_q;
  logic [HALF_W-1:0]             h_q;
  logic [CNT_W-1:0]              len_q;
  logic signed [COV_W-1:0]       covr_q;
  logic signed [PROD_W-1:0]      prod_q;
  logic                          slope_first_q;
  logic                          short_q;
  logic [SLOPE_W-1:0]            slope_q;
  logic                          last_q;
  logic                          short_out_q;

  logic [HALF_W-1:0]             h_eff;
  logic [CNT_W-1:0]              len_eff;
  logic [CNT_W-1:0]              wp_ext;
  logic [CNT_W-1:0]              raddr_full;
  logic [AW-1:0]                 raddr;
  logic signed [SAMPLE_BITS-1:0] x_out;
  logic [COV_W-1:0]              xo_c;
  logic [COV_W-1:0]              xn_c;
  logic [COV_W-1:0]              sum_c;
  logic [COV_W-1:0]              h_c;
  logic [COV_W-1:0]              hp1_c;
  logic [COV_W-1:0]              cov_new;
  logic [SUM_W-1:0]              sum_new;
  logic [CNT_W-1:0]              h_cnt;
  logic [CNT_W-1:0]              lead_n;
  logic [CNT_W-1:0]              remain;
  logic [RES_W-1:0]              n_res;
  logic                          plan_slope;
  logic                          plan_short;
  logic [QS_W-1:0]               qs;
  logic                          fits;
  logic [SLOPE_W-1:0]            sat;

  always_comb begin
    if (half_width_i == '0) begin
      h_eff = HALF_W'(1);
    end else if (int'(half_width_i) > MAX_HALF) begin
      h_eff = HALF_W'(MAX_HALF);
    end else begin
      h_eff = HALF_W'(half_width_i);
    end
  end

  assign len_eff = {h_eff, 1'b1};
  assign wp_ext  = CNT_W'(wp_q);

  always_comb begin
    if (wp_ext >= len_eff) begin
      raddr_full = wp_ext - len_eff;
    end else begin
      raddr_full = CNT_W'(DEPTH) - (len_eff - wp_ext);
    end
  end

  assign raddr = AW'(raddr_full);

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      store_mem[wp_q] <= sample_i;
      xo_q            <= store_mem[raddr];
    end
  end

  // recursive update of covariance and window sum
  assign x_out   = xo_ok_q ? xo_q : '0;
  assign xo_c    = COV_W'(x_out);
  assign xn_c    = COV_W'(x_q);
  assign sum_c   = COV_W'(sum_q);
  assign h_c     = COV_W'(h_q);
  assign hp1_c   = COV_W'(h_q) + COV_W'(1);
  assign cov_new = COV_W'(cov_q) - sum_c + hp1_c * xo_c + h_c * xn_c;
  assign sum_new = SUM_W'(sum_q) - SUM_W'(x_out) + SUM_W'(x_q);

  // results this item causes
  assign h_cnt  = CNT_W'(h_q);
  assign lead_n = (fill_q < h_cnt) ? fill_q : h_cnt;
  assign remain = fill_q + CNT_W'(1) - lead_n;

  always_comb begin
    n_res      = '0;
    plan_slope = 1'b0;
    plan_short = 1'b0;
    if (end_q) begin
      if (fill_q >= len_q) begin
        n_res      = RES_W'(h_cnt + CNT_W'(1));
        plan_slope = 1'b1;
      end else begin
        n_res      = RES_W'(remain);
        plan_short = 1'b1;
      end
    end else if (fill_q < h_cnt) begin
      n_res = RES_W'(1);
    end else if (fill_q >= len_q - CNT_W'(1)) begin
      n_res      = RES_W'(1);
      plan_slope = 1'b1;
    end
  end

  // drop 16 fraction bits (floor), saturate to the slope range
  assign qs   = prod_q[PROD_W-1:FRAC_W];
  assign fits = (&qs[QS_W-1:SLOPE_W-1]) || !(|qs[QS_W-1:SLOPE_W-1]);
  assign sat  = fits ? qs[SLOPE_W-1:0] : (qs[QS_W-1] ? SLOPE_MIN : SLOPE_MAX);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q    <= '0;
      fill_q  <= '0;
      hcnt_q  <= '0;
      cov_q   <= '0;
      sum_q   <= '0;
      rem_q   <= '0;
      first_q <= 1'b0;
    end else begin
      if (cmd_i.accept) begin
        wp_q <= (wp_q == AW'(DEPTH - 1)) ? '0 : wp_q + AW'(1);
      end
      if (cmd_i.update) begin
        rem_q   <= n_res;
        first_q <= 1'b1;
        if (end_q) begin
          fill_q <= '0;
          hcnt_q <= '0;
          cov_q  <= '0;
          sum_q  <= '0;
        end else begin
          fill_q <= (fill_q < len_q) ? fill_q + CNT_W'(1) : fill_q;
          hcnt_q <= (hcnt_q < CNT_W'(DEPTH)) ? hcnt_q + CNT_W'(1) : hcnt_q;
          cov_q  <= cov_new;
          sum_q  <= sum_new;
        end
      end
      if (cmd_i.load) begin
        rem_q   <= rem_q - RES_W'(1);
        first_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      x_q     <= sample_i;
      end_q   <= column_end_i;
      h_q     <= h_eff;
      len_q   <= len_eff;
      xo_ok_q <= (hcnt_q >= len_eff);
    end
    if (cmd_i.update) begin
      covr_q        <= cov_new;
      slope_first_q <= plan_slope;
      short_q       <= plan_short;
    end
    if (cmd_i.mult) begin
      prod_q <= PROD_W'(covr_q) * $signed(PROD_W'(slope_scale_i));
    end
    if (cmd_i.load) begin
      slope_q     <= (first_q && slope_first_q) ? sat : '0;
      last_q      <= end_q && (rem_q == RES_W'(1));
      short_out_q <= short_q;
    end
  end

  assign sts_o.none      = (rem_q == '0);
  assign sts_o.final_res = (rem_q == RES_W'(1));

  assign slope_o        = slope_q;
  assign last_o         = last_q;
  assign short_column_o = short_out_q;

  `LSQS_CHECK(a_hist_bounded, clk_i, rst_ni, 1'b1, hcnt_q <= CNT_W'(DEPTH))
  `LSQS_CHECK(a_rem_bounded, clk_i, rst_ni, 1'b1, int'(rem_q) <= MAX_HALF + 1)

endmodule

`default_nettype wire

/* rtl/core/lsq_slope_sliding_window.sv */
// Least-squares slope over a centered window of 2h+1 samples, streamed one
// column at a time: each sample updates a running covariance and window sum,
// the covariance is scaled by slope_scale and truncated to Q.16 with
// saturation, and the h edge positions at each end of a column give zero. An
// item passes through the history memory read, the recursive update and the
// scale multiply, then gives one result per cycle (up to h+1) while the
// output does not stall; the next sample is taken as soon as the last result
// of the previous one sits in the output register. No clearing pass is needed
// after reset: a fill count masks history memory entries of earlier columns.
// Depends on lsqs_pkg, lsqs_ctrl and lsqs_datapath.
`default_nettype none

module lsq_slope_sliding_window #(
  parameter int MAX_HALF    = 15,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic signed [SAMPLE_BITS-1:0]       sample_i,
  input  logic                                column_end_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [lsqs_pkg::SLOPE_W-1:0] slope_o,
  output logic                                last_o,
  output logic                                short_column_o,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [lsqs_pkg::ADDR_W-1:0]         paddr,
  input  logic [lsqs_pkg::DATA_W-1:0]         pwdata,
  output logic [lsqs_pkg::DATA_W-1:0]         prdata,
  output logic                                pready
);
  import lsqs_pkg::*;

  logic [HW_W-1:0]    half_q;
  logic [SCALE_W-1:0] scale_q;
  logic               cfg_wr;
  ctrl_cmd_t          cmd;
  ctrl_sts_t          sts;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_q  <= HALF_RESET;
      scale_q <= SCALE_RESET;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_HALF:  half_q  <= pwdata[HW_W-1:0];
        REG_SCALE: scale_q <= pwdata[SCALE_W-1:0];
        default:   half_q  <= half_q;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_HALF:  prdata = DATA_W'(half_q);
      REG_SCALE: prdata = DATA_W'(scale_q);
      default:   prdata = '0;
    endcase
  end

  lsqs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  lsqs_datapath #(
    .MAX_HALF    (MAX_HALF),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .sample_i       (sample_i),
    .column_end_i   (column_end_i),
    .half_width_i   (half_q),
    .slope_scale_i  (scale_q),
    .slope_o        (slope_o),
    .last_o         (last_o),
    .short_column_o (short_column_o)
  );

endmodule

`default_nettype wire
